// File: design/sgb_pkg.sv
package sgb_pkg;

	localparam int PIX_W  = 8;
	localparam int NUM_CH = 3;
	localparam int PX_W   = PIX_W * NUM_CH;
	localparam int DIM_W  = 12;
	localparam int SUM_W  = 12;
	localparam int RCP_W  = 17;
	localparam int RCP_SH = 18;
	localparam int PROD_W = SUM_W + RCP_W;
	localparam int CNT_W  = 14;

	// Which outer taps of the 1-2-4-2-1 kernel fall inside the frame
	typedef struct packed {
		logic lo2;
		logic lo1;
		logic hi1;
		logic hi2;
	} tap_mask_t;

	// Control that follows one item down the pipeline
	typedef struct packed {
		logic hb_vld;
		logic prod;
		logic row_end;
		logic frame_end;
	} item_ctl_t;

	typedef logic [4:0][PIX_W-1:0] taps_t;

	// Weighted sum of the taps that are inside the frame; tap 2 is the center
	function automatic logic [SUM_W-1:0] tap_sum(input taps_t t, input tap_mask_t m);
		logic [SUM_W-1:0] s;
		s = SUM_W'(t[2]) << 2;
		if (m.lo2) s = s + SUM_W'(t[0]);
		if (m.lo1) s = s + (SUM_W'(t[1]) << 1);
		if (m.hi1) s = s + (SUM_W'(t[3]) << 1);
		if (m.hi2) s = s + SUM_W'(t[4]);
		return s;
	endfunction

	// ceil(2^18 / weight sum) for every weight sum a contiguous window can give
	function automatic logic [RCP_W-1:0] recip(input tap_mask_t m);
		logic [3:0] d;
		logic [RCP_W-1:0] r;
		d = 4'd4 + {2'b00, m.lo1, 1'b0} + {2'b00, m.hi1, 1'b0}
			+ {3'b000, m.lo2} + {3'b000, m.hi2};
		case (d)
			4'd4:    r = RCP_W'(65536);
			4'd5:    r = RCP_W'(52429);
			4'd6:    r = RCP_W'(43691);
			4'd7:    r = RCP_W'(37450);
			4'd8:    r = RCP_W'(32768);
			4'd9:    r = RCP_W'(29128);
			4'd10:   r = RCP_W'(26215);
			default: r = RCP_W'(65536);
		endcase
		return r;
	endfunction

endpackage

// File: design/sgb_hlane.sv
module sgb_hlane
	import sgb_pkg::*;
(
	input  logic             clk,
	input  logic             en,
	input  taps_t            taps,
	input  tap_mask_t        mask,
	output logic [PIX_W-1:0] hval
);

	logic [SUM_W-1:0]  sum_s1;
	logic [RCP_W-1:0]  rcp_s1;
	logic [PROD_W-1:0] prod;
	logic [PIX_W-1:0]  hval_s2;

	// Sum the row taps, then divide by the weight sum through its reciprocal
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1  <= tap_sum(taps, mask);
			rcp_s1  <= recip(mask);
			hval_s2 <= prod[RCP_SH +: PIX_W];
		end
	end

	assign prod = PROD_W'(sum_s1) * PROD_W'(rcp_s1);
	assign hval = hval_s2;

endmodule

// File: design/sgb_vlane.sv
module sgb_vlane
	import sgb_pkg::*;
(
	input  logic             clk,
	input  logic             en,
	input  taps_t            taps,
	input  tap_mask_t        mask,
	output logic [PIX_W-1:0] res
);

	logic [PROD_W-1:0] prod;
	logic [PIX_W-1:0]  res_q;

	// Column sum and divide, straight into the output register
	assign prod = PROD_W'(tap_sum(taps, mask)) * PROD_W'(recip(mask));

	always_ff @(posedge clk) begin
		if (en) res_q <= prod[RCP_SH +: PIX_W];
	end

	assign res = res_q;

endmodule

// File: design/sgb_linebank.sv
module sgb_linebank
	import sgb_pkg::*;
#(
	parameter int DEPTH = 2048,
	parameter int AW    = 11
) (
	input  logic            clk,
	input  logic            en,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  logic [PX_W-1:0] wdata,
	input  logic [AW-1:0]   raddr,
	output logic [PX_W-1:0] rdata
);

	logic [PX_W-1:0] mem [DEPTH];
	logic [PX_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en && we) mem[waddr] <= wdata;
	end

	// Write-first read; bypass the value written in the same cycle
	always_ff @(posedge clk) begin
		if (en) rdata_q <= (we && waddr == raddr) ? wdata : mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: design/separable_gaussian_blur_5x5.sv
// Pipeline: a result passes the s1, s2 and output registers after the item
// that completes it, and that item comes 2*width+2 items after the source
// pixel. Throughput: one item per cycle while the output is not stalled, set
// by the line store ports and the per-channel lanes; flush items push out the
// last 2*width+2 results. Reset: asynchronous, clears registers to 640x480
// and all positions; line stores are not cleared and need no clearing pass.
module separable_gaussian_blur_5x5
	import sgb_pkg::*;
#(
	parameter int MAX_WIDTH = 2048
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_axis_tvalid,
	output logic            s_axis_tready,
	input  logic [PX_W-1:0] s_axis_tdata,   // blue_in, green_in, red_in
	input  logic            s_axis_tuser,   // func
	output logic            m_axis_tvalid,
	input  logic            m_axis_tready,
	output logic [PX_W-1:0] m_axis_tdata,   // blue_out, green_out, red_out
	output logic            m_axis_tlast,   // row_end
	output logic            m_axis_tuser,   // frame_end
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic            cfg_index,
	input  logic [DIM_W-1:0] cfg_data
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int CMP_W = ((COL_W > DIM_W) ? COL_W : DIM_W) + 1;

	typedef enum logic {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;

	logic [DIM_W-1:0] width_q, height_q, w_eff, h_eff;
	logic [COL_W-1:0] in_col_q, hb_col_q, out_col_q;
	logic [DIM_W-1:0] in_row_q, out_row_q;
	logic [1:0]       hb_row_q;
	logic [CNT_W-1:0] cnt_q, cap, cnt_nx;
	logic [3:0][PX_W-1:0] win_q;

	logic en, acc, in_live, take, hb_act, out_act, row_end, frame_end;
	logic [PX_W-1:0] cur;
	tap_mask_t hmask, vmask;

	item_ctl_t        ctl_s1, ctl_s2;
	tap_mask_t        vmask_s1, vmask_s2;
	logic [1:0]       wbank_s1, wbank_s2, orow_s1, orow_s2;
	logic [COL_W-1:0] waddr_s1, waddr_s2, raddr_s1;
	logic             m_valid_q, m_last_q, m_user_q;

	logic [PX_W-1:0]       hval;
	logic [3:0][PX_W-1:0]  rd;

	// Effective frame size
	always_comb begin
		if (width_q == '0) w_eff = DIM_W'(1);
		else if (32'(width_q) > MAX_WIDTH) w_eff = DIM_W'(MAX_WIDTH);
		else w_eff = width_q;
		h_eff = (height_q == '0) ? DIM_W'(1) : height_q;
	end

	assign en            = !m_valid_q || m_axis_tready;
	assign s_axis_tready = en;
	assign cfg_ready     = 1'b1;
	assign acc           = s_axis_tvalid && en;
	assign in_live       = in_row_q < h_eff;
	assign take          = acc && !(in_live && s_axis_tuser);
	assign cur           = in_live ? s_axis_tdata : '0;

	assign cap     = (CNT_W'(w_eff) << 1) + CNT_W'(3);
	assign cnt_nx  = cnt_q + CNT_W'(1);
	assign hb_act  = cnt_nx >= CNT_W'(3);
	assign out_act = cnt_nx >= cap;

	// Which taps lie inside the frame at the current positions
	always_comb begin
		hmask.lo2 = CMP_W'(hb_col_q) >= CMP_W'(2);
		hmask.lo1 = CMP_W'(hb_col_q) >= CMP_W'(1);
		hmask.hi1 = CMP_W'(hb_col_q) + CMP_W'(1) < CMP_W'(w_eff);
		hmask.hi2 = CMP_W'(hb_col_q) + CMP_W'(2) < CMP_W'(w_eff);
		vmask.lo2 = out_row_q >= DIM_W'(2);
		vmask.lo1 = out_row_q >= DIM_W'(1);
		vmask.hi1 = (CMP_W'(out_row_q) + CMP_W'(1)) < CMP_W'(h_eff);
		vmask.hi2 = (CMP_W'(out_row_q) + CMP_W'(2)) < CMP_W'(h_eff);
	end

	assign row_end   = CMP_W'(out_col_q) == CMP_W'(w_eff) - CMP_W'(1);
	assign frame_end = row_end && out_row_q == h_eff - DIM_W'(1);

	// Registers, positions and the row window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= DIM_W'(640);
			height_q  <= DIM_W'(480);
			in_col_q  <= '0;
			in_row_q  <= '0;
			hb_col_q  <= '0;
			hb_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			cnt_q     <= '0;
			win_q     <= '0;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default:    width_q  <= cfg_data;
			endcase
			in_col_q  <= '0;
			in_row_q  <= '0;
			hb_col_q  <= '0;
			hb_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			cnt_q     <= '0;
			win_q     <= '0;
		end else if (take) begin
			if (out_act && frame_end) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				hb_col_q  <= '0;
				hb_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
				cnt_q     <= '0;
				win_q     <= '0;
			end else begin
				if (in_live) begin
					if (CMP_W'(in_col_q) + CMP_W'(1) >= CMP_W'(w_eff)) begin
						in_col_q <= '0;
						in_row_q <= in_row_q + DIM_W'(1);
					end else begin
						in_col_q <= in_col_q + COL_W'(1);
					end
				end
				if (cnt_q < cap) cnt_q <= cnt_nx;
				if (hb_act) begin
					if (CMP_W'(hb_col_q) + CMP_W'(1) >= CMP_W'(w_eff)) begin
						hb_col_q <= '0;
						hb_row_q <= hb_row_q + 2'd1;
					end else begin
						hb_col_q <= hb_col_q + COL_W'(1);
					end
				end
				if (out_act) begin
					if (row_end) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + DIM_W'(1);
					end else begin
						out_col_q <= out_col_q + COL_W'(1);
					end
				end
				win_q <= {cur, win_q[3:1]};
			end
		end
	end

	// Advance control through the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1    <= '0;
			ctl_s2    <= '0;
			m_valid_q <= 1'b0;
		end else if (en) begin
			ctl_s1.hb_vld    <= take && hb_act;
			ctl_s1.prod      <= take && out_act;
			ctl_s1.row_end   <= row_end;
			ctl_s1.frame_end <= frame_end;
			ctl_s2           <= ctl_s1;
			m_valid_q        <= ctl_s2.prod;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vmask_s1 <= vmask;
			vmask_s2 <= vmask_s1;
			wbank_s1 <= hb_row_q;
			wbank_s2 <= wbank_s1;
			waddr_s1 <= hb_col_q;
			waddr_s2 <= waddr_s1;
			raddr_s1 <= out_col_q;
			orow_s1  <= out_row_q[1:0];
			orow_s2  <= orow_s1;
			m_last_q <= ctl_s2.row_end;
			m_user_q <= ctl_s2.frame_end;
		end
	end

	// Four line stores of horizontal results, one per row modulo four
	for (genvar b = 0; b < 4; b++) begin : g_bank
		sgb_linebank #(
			.DEPTH(MAX_WIDTH),
			.AW   (COL_W)
		) u_bank (
			.clk  (clk),
			.en   (en),
			.we   (ctl_s2.hb_vld && wbank_s2 == 2'(b)),
			.waddr(waddr_s2),
			.wdata(hval),
			.raddr(raddr_s1),
			.rdata(rd[b])
		);
	end

	// One horizontal and one vertical lane per channel
	for (genvar k = 0; k < NUM_CH; k++) begin : g_lane
		taps_t htaps, vtaps;

		assign htaps = {cur[k*PIX_W +: PIX_W], win_q[3][k*PIX_W +: PIX_W],
			win_q[2][k*PIX_W +: PIX_W], win_q[1][k*PIX_W +: PIX_W],
			win_q[0][k*PIX_W +: PIX_W]};

		assign vtaps = {hval[k*PIX_W +: PIX_W],
			rd[orow_s2 + 2'd1][k*PIX_W +: PIX_W],
			rd[orow_s2][k*PIX_W +: PIX_W],
			rd[orow_s2 - 2'd1][k*PIX_W +: PIX_W],
			rd[orow_s2 - 2'd2][k*PIX_W +: PIX_W]};

		sgb_hlane u_h (
			.clk (clk),
			.en  (en),
			.taps(htaps),
			.mask(hmask),
			.hval(hval[k*PIX_W +: PIX_W])
		);

		sgb_vlane u_v (
			.clk (clk),
			.en  (en),
			.taps(vtaps),
			.mask(vmask_s2),
			.res (m_axis_tdata[k*PIX_W +: PIX_W])
		);
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tlast  = m_last_q;
	assign m_axis_tuser  = m_user_q;

endmodule
